@@ hdl/tctd_pkg.sv @@
// Shared types, constants and helper functions for the text cell tile downsampler.
// Depends on nothing; every other file of the block imports it.
package tctd_pkg;

    localparam int TCTD_MAX_TILE_SIDE = 16;
    localparam int TCTD_CFG_W         = 5;
    localparam int TCTD_Q_DEPTH       = 2;

    localparam logic [TCTD_CFG_W-1:0] TCTD_SIDE_RESET = TCTD_CFG_W'(4);

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    localparam logic [7:0] SHADE_LIGHT  = 8'hB0;
    localparam logic [7:0] SHADE_MEDIUM = 8'hB1;
    localparam logic [7:0] SHADE_DARK   = 8'hB2;
    localparam logic [7:0] SHADE_FULL   = 8'hDB;

    typedef enum logic [0:0] {
        CFG_TILE_WIDTH  = 1'b0,
        CFG_TILE_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
        logic       frame_start;
    } t_cell_in;

    typedef struct packed {
        logic [7:0] tile_char;
        logic [3:0] tile_attr;
        logic       attr_changed;
    } t_tile_out;

    // Handshake between the front end and the tile queue.
    typedef struct packed {
        logic push;
        logic full;
    } t_q_wr_ctl;

    // Handshake between the tile queue and the back end.
    typedef struct packed {
        logic pop;
        logic empty;
    } t_q_rd_ctl;

    function automatic logic [7:0] shade_char(input logic [1:0] level_lo);
        logic [7:0] ch;
        unique case (level_lo)
            2'd0:    ch = SHADE_LIGHT;
            2'd1:    ch = SHADE_MEDIUM;
            2'd2:    ch = SHADE_DARK;
            default: ch = SHADE_FULL;
        endcase
        return ch;
    endfunction

endpackage

@@ hdl/tctd_front.sv @@
// Front end: takes cells, picks the colour, accumulates channel totals per tile
// and pushes one finished tile summary into the queue. Uses tctd_pkg.
module tctd_front #(
    parameter int MAX_TILE_SIDE = tctd_pkg::TCTD_MAX_TILE_SIDE,
    parameter int ENTRY_W       = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  tctd_pkg::t_cell_in                  i_cell,
    input  logic [tctd_pkg::TCTD_CFG_W-1:0]     i_tile_width,
    input  logic [tctd_pkg::TCTD_CFG_W-1:0]     i_tile_height,
    output tctd_pkg::t_q_wr_ctl                 o_q_ctl,
    input  logic                                i_q_full,
    output logic [ENTRY_W-1:0]                  o_entry
);
    import tctd_pkg::*;

    localparam int SIDE_W = $clog2(MAX_TILE_SIDE + 1);
    localparam int CW     = (SIDE_W > TCTD_CFG_W) ? SIDE_W : TCTD_CFG_W;
    localparam int AREA   = MAX_TILE_SIDE * MAX_TILE_SIDE;
    localparam int N_W    = $clog2(AREA + 1);
    localparam int CNT_W  = (AREA > 1) ? $clog2(AREA) : 1;
    localparam int TOT_W  = $clog2(2 * AREA + 1);

    logic [CNT_W-1:0] r_count, n_count;
    logic [TOT_W-1:0] r_red, n_red, r_green, n_green, r_blue, n_blue;
    logic             r_frame_pend, n_frame_pend;

    logic [CW-1:0]     w_ext, h_ext;
    logic [SIDE_W-1:0] w_side, h_side;
    logic [N_W-1:0]    tile_n, cnt_next;
    logic [TOT_W-1:0]  red_next, green_next, blue_next;
    logic [3:0]        colour;
    logic [1:0]        inc_r, inc_g, inc_b;
    logic              accept, done, start;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign start   = i_cell.frame_start;

    always_comb begin
        w_ext  = CW'(i_tile_width);
        h_ext  = CW'(i_tile_height);
        w_side = (w_ext == '0) ? SIDE_W'(1)
               : (w_ext > CW'(MAX_TILE_SIDE)) ? SIDE_W'(MAX_TILE_SIDE) : SIDE_W'(w_ext);
        h_side = (h_ext == '0) ? SIDE_W'(1)
               : (h_ext > CW'(MAX_TILE_SIDE)) ? SIDE_W'(MAX_TILE_SIDE) : SIDE_W'(h_ext);
        tile_n = N_W'(w_side) * N_W'(h_side);
    end

    always_comb begin
        colour = (i_cell.cell_char == CHAR_NUL || i_cell.cell_char == CHAR_SPACE)
               ? i_cell.cell_attr[7:4] : i_cell.cell_attr[3:0];
        inc_r  = {colour[3] & colour[2], ~colour[3] & colour[2]};
        inc_g  = {colour[3] & colour[1], ~colour[3] & colour[1]};
        inc_b  = {colour[3] & colour[0], ~colour[3] & colour[0]};
        // A frame start drops whatever partial tile was being built.
        cnt_next   = (start ? '0 : N_W'(r_count)) + N_W'(1);
        red_next   = (start ? '0 : r_red)   + TOT_W'(inc_r);
        green_next = (start ? '0 : r_green) + TOT_W'(inc_g);
        blue_next  = (start ? '0 : r_blue)  + TOT_W'(inc_b);
        done       = cnt_next >= tile_n;

        n_count      = r_count;
        n_red        = r_red;
        n_green      = r_green;
        n_blue       = r_blue;
        n_frame_pend = r_frame_pend;
        if (accept) begin
            if (done) begin
                n_count      = '0;
                n_red        = '0;
                n_green      = '0;
                n_blue       = '0;
                n_frame_pend = 1'b0;
            end else begin
                n_count      = CNT_W'(cnt_next);
                n_red        = red_next;
                n_green      = green_next;
                n_blue       = blue_next;
                n_frame_pend = r_frame_pend | start;
            end
        end
    end

    assign o_q_ctl.push = accept && done;
    assign o_q_ctl.full = i_q_full;
    assign o_entry = ENTRY_W'({r_frame_pend | start, tile_n, red_next, green_next, blue_next});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_red        <= '0;
            r_green      <= '0;
            r_blue       <= '0;
            r_frame_pend <= 1'b0;
        end else begin
            r_count      <= n_count;
            r_red        <= n_red;
            r_green      <= n_green;
            r_blue       <= n_blue;
            r_frame_pend <= n_frame_pend;
        end
    end

    a_push_clears_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_ctl.push |=> (r_frame_pend == 1'b0 && r_count == '0))
        else $error("tile push did not clear the tile accumulators");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_ctl.push |-> !i_q_full)
        else $error("tile pushed into a full queue");

    a_start_discards: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && start && !done) |=> (r_count == CNT_W'(1) && r_frame_pend))
        else $error("frame start did not restart the tile");

endmodule

@@ hdl/tctd_queue.sv @@
// Short queue of finished tile summaries between the front end and the back end.
// Uses tctd_pkg for its depth and handshake structs.
module tctd_queue #(
    parameter int ENTRY_W = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tctd_pkg::t_q_wr_ctl  i_wr,
    input  logic [ENTRY_W-1:0]   i_entry,
    output logic                 o_full,
    input  logic                 i_pop,
    output tctd_pkg::t_q_rd_ctl  o_rd,
    output logic [ENTRY_W-1:0]   o_entry
);
    import tctd_pkg::*;

    localparam int AW  = (TCTD_Q_DEPTH > 1) ? $clog2(TCTD_Q_DEPTH) : 1;
    localparam int CNW = $clog2(TCTD_Q_DEPTH + 1);

    logic [ENTRY_W-1:0] r_slot [TCTD_Q_DEPTH];
    logic [AW-1:0]      r_wr_ptr, n_wr_ptr, r_rd_ptr, n_rd_ptr;
    logic [CNW-1:0]     r_fill, n_fill;
    logic               empty, do_push, do_pop;

    assign empty   = (r_fill == '0);
    assign o_full  = (r_fill == CNW'(TCTD_Q_DEPTH));
    assign do_push = i_wr.push && !o_full;
    assign do_pop  = i_pop && !empty;
    assign o_entry = r_slot[r_rd_ptr];
    assign o_rd.pop   = do_pop;
    assign o_rd.empty = empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(TCTD_Q_DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(TCTD_Q_DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_fill = r_fill + CNW'(1);
        end else if (do_pop && !do_push) begin
            n_fill = r_fill - CNW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNW'(TCTD_Q_DEPTH))
        else $error("queue fill count out of range");

    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && empty) |=> !empty)
        else $error("pushed word did not appear in the queue");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == '0 || o_full) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with the fill count");

endmodule

@@ hdl/tctd_back.sv @@
// Back end: turns one tile summary into the shade character, attribute and change
// flag, and holds the result in an output register. Uses tctd_pkg.
module tctd_back #(
    parameter int MAX_TILE_SIDE = tctd_pkg::TCTD_MAX_TILE_SIDE,
    parameter int ENTRY_W       = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tctd_pkg::t_q_rd_ctl  i_q,
    input  logic [ENTRY_W-1:0]   i_entry,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output tctd_pkg::t_tile_out  o_tile
);
    import tctd_pkg::*;

    localparam int AREA  = MAX_TILE_SIDE * MAX_TILE_SIDE;
    localparam int N_W   = $clog2(AREA + 1);
    localparam int TOT_W = $clog2(2 * AREA + 1);
    localparam int CMP_W = TOT_W + 6;

    logic              r_valid, n_valid;
    logic [3:0]        r_prev, n_prev;
    t_tile_out         r_tile, n_tile;

    logic              clear_prev;
    logic [N_W-1:0]    tile_n;
    logic [TOT_W-1:0]  red, green, blue;
    logic [CMP_W-1:0]  n_ext, s4;
    logic [6:0]        above;
    logic [2:0]        level;
    logic [3:0]        tattr, prev_eff;

    assign {clear_prev, tile_n, red, green, blue} = i_entry[1 + N_W + 3 * TOT_W - 1:0];

    assign o_pop = !i_q.empty && (!r_valid || i_ready);

    always_comb begin
        n_ext = CMP_W'(tile_n);
        // Four times the weighted sum 3R + 2G + 3B, against nine k N for each level k.
        s4 = (CMP_W'(red) * CMP_W'(12)) + (CMP_W'(green) * CMP_W'(8))
           + (CMP_W'(blue) * CMP_W'(12));
        for (int k = 1; k <= 7; k++) begin
            above[k-1] = s4 > (n_ext * CMP_W'(9 * k));
        end
        // The thresholds rise with k, so the level is the count of those exceeded.
        level = 3'($countones(above));
        tattr = {level[2],
                 (CMP_W'(red) << 1) >= n_ext,
                 (CMP_W'(green) << 2) >= (n_ext * CMP_W'(3)),
                 (CMP_W'(blue) << 1) >= n_ext};
        prev_eff = clear_prev ? 4'd0 : r_prev;

        n_valid = r_valid;
        n_prev  = r_prev;
        n_tile  = r_tile;
        if (r_valid && i_ready) begin
            n_valid = 1'b0;
        end
        if (o_pop) begin
            n_valid             = 1'b1;
            n_prev              = tattr;
            n_tile.tile_char    = shade_char(level[1:0]);
            n_tile.tile_attr    = tattr;
            n_tile.attr_changed = (tattr != prev_eff);
        end
    end

    assign o_valid = r_valid;
    assign o_tile  = r_tile;

    always_ff @(posedge i_clk) begin
        r_tile <= n_tile;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_prev  <= 4'd0;
        end else begin
            r_valid <= n_valid;
            r_prev  <= n_prev;
        end
    end

    a_pop_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_valid && r_tile.tile_attr == r_prev))
        else $error("popped tile did not reach the output register");

    a_pop_only_with_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (!i_q.empty && (!r_valid || i_ready)))
        else $error("tile popped without room in the output register");

    a_full_shade_intense: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_tile.tile_char == SHADE_FULL && r_tile.tile_attr[3])
            |-> (r_tile.tile_attr != 4'd0))
        else $error("inconsistent intense shade result");

endmodule

@@ hdl/text_cell_tile_downsampler.sv @@
// Top level of the text cell tile downsampler: configuration registers, front end,
// tile queue and back end. Depends on tctd_pkg, tctd_front, tctd_queue, tctd_back.
//
// The block takes one cell word per clock, every clock, as long as the two-entry tile
// queue has room; the colour pick and channel accumulation in the front end set that
// rate. A tile result is written into the queue at the edge that takes the tile's last
// cell and moves on into the output register once that register has room; the output
// register lets the next tile proceed while a result waits to be taken. Tile sides are
// set by two write-only registers (index 0 width, index 1 height, reset 4 by 4); a side
// of zero acts as one and a side above MAX_TILE_SIDE acts as MAX_TILE_SIDE. A cell with
// frame_start set discards any partial tile and compares the next tile against zero.
module text_cell_tile_downsampler #(
    parameter int MAX_TILE_SIDE = tctd_pkg::TCTD_MAX_TILE_SIDE
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cell_valid,
    output logic                             o_cell_ready,
    input  tctd_pkg::t_cell_in               i_cell,
    output logic                             o_tile_valid,
    input  logic                             i_tile_ready,
    output tctd_pkg::t_tile_out              o_tile,
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_idx,
    input  logic [tctd_pkg::TCTD_CFG_W-1:0]  i_cfg_data
);
    import tctd_pkg::*;

    localparam int AREA    = MAX_TILE_SIDE * MAX_TILE_SIDE;
    localparam int N_W     = $clog2(AREA + 1);
    localparam int TOT_W   = $clog2(2 * AREA + 1);
    localparam int ENTRY_W = 1 + N_W + 3 * TOT_W;

    logic [TCTD_CFG_W-1:0] r_tile_width, n_tile_width;
    logic [TCTD_CFG_W-1:0] r_tile_height, n_tile_height;

    t_q_wr_ctl          q_wr;
    t_q_rd_ctl          q_rd;
    logic               q_full, q_pop;
    logic [ENTRY_W-1:0] front_entry, head_entry;

    always_comb begin
        n_tile_width  = r_tile_width;
        n_tile_height = r_tile_height;
        if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_TILE_WIDTH:  n_tile_width  = i_cfg_data;
                CFG_TILE_HEIGHT: n_tile_height = i_cfg_data;
                default:         n_tile_width  = r_tile_width;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_width  <= TCTD_SIDE_RESET;
            r_tile_height <= TCTD_SIDE_RESET;
        end else begin
            r_tile_width  <= n_tile_width;
            r_tile_height <= n_tile_height;
        end
    end

    tctd_front #(
        .MAX_TILE_SIDE (MAX_TILE_SIDE),
        .ENTRY_W       (ENTRY_W)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_cell_valid),
        .o_ready       (o_cell_ready),
        .i_cell        (i_cell),
        .i_tile_width  (r_tile_width),
        .i_tile_height (r_tile_height),
        .o_q_ctl       (q_wr),
        .i_q_full      (q_full),
        .o_entry       (front_entry)
    );

    tctd_queue #(
        .ENTRY_W (ENTRY_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_entry (front_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_rd    (q_rd),
        .o_entry (head_entry)
    );

    tctd_back #(
        .MAX_TILE_SIDE (MAX_TILE_SIDE),
        .ENTRY_W       (ENTRY_W)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q     (q_rd),
        .i_entry (head_entry),
        .o_pop   (q_pop),
        .o_valid (o_tile_valid),
        .i_ready (i_tile_ready),
        .o_tile  (o_tile)
    );

endmodule

@@ dv/tb_text_cell_tile_downsampler.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for text_cell_tile_downsampler: a queue-fed cell driver, a tile
// monitor and an in-bench tile predictor with its own copy of the size registers.
// Depends on tctd_pkg and the RTL of the block only.
module tb_text_cell_tile_downsampler;
    import tctd_pkg::*;

    localparam int HOLD_CYCLES = 150;

    typedef enum int {
        IDLE_RX_HEAVY,
        IDLE_TX_HEAVY,
        IDLE_NONE
    } t_idle_mode;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cell_valid = 1'b0;
    logic                  o_cell_ready;
    t_cell_in              i_cell = '0;
    logic                  o_tile_valid;
    logic                  i_tile_ready = 1'b0;
    t_tile_out             o_tile;
    logic                  i_cfg_we = 1'b0;
    logic                  i_cfg_idx = 1'b0;
    logic [TCTD_CFG_W-1:0] i_cfg_data = '0;

    t_idle_mode  idle_mode = IDLE_RX_HEAVY;
    t_cell_in    cells_todo[$];
    t_tile_out   tiles_due[$];
    t_tile_out   tile_want;
    int unsigned cells_queued = 0;
    int unsigned cells_taken = 0;
    int unsigned tiles_checked = 0;
    int unsigned fail_count = 0;
    int          hold_req = 0;
    int          hold_taken = 0;
    int          hold_left = 0;

    // Predictor state: size registers as written, plus the running tile.
    logic [TCTD_CFG_W-1:0] tile_w;
    logic [TCTD_CFG_W-1:0] tile_h;
    int unsigned           cells_in_tile;
    int unsigned           red_sum;
    int unsigned           green_sum;
    int unsigned           blue_sum;
    logic [3:0]            last_attr;

    text_cell_tile_downsampler DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cell_valid (i_cell_valid),
        .o_cell_ready (o_cell_ready),
        .i_cell       (i_cell),
        .o_tile_valid (o_tile_valid),
        .i_tile_ready (i_tile_ready),
        .o_tile       (o_tile),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int idle_pct(input bit rx_side);
        case (idle_mode)
            IDLE_RX_HEAVY: return rx_side ? 46 : 13;
            IDLE_TX_HEAVY: return rx_side ? 13 : 46;
            default:       return 0;
        endcase
    endfunction

    function automatic int unsigned eff_side(input logic [TCTD_CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > TCTD_MAX_TILE_SIDE)
            return TCTD_MAX_TILE_SIDE;
        return v;
    endfunction

    function automatic void clear_tile();
        cells_in_tile = 0;
        red_sum = 0;
        green_sum = 0;
        blue_sum = 0;
    endfunction

    // Adds one cell to the running tile and, on the tile's last cell, queues the
    // shade, attribute and change flag that the block must produce.
    task automatic accumulate_cell(input t_cell_in c);
        logic [3:0]  colour;
        int unsigned r, g, b, n, s, lvl, k;
        t_tile_out   t;
        if (c.frame_start) begin
            last_attr = '0;
            clear_tile();
        end
        colour = (c.cell_char == CHAR_NUL || c.cell_char == CHAR_SPACE) ?
                 c.cell_attr[7:4] : c.cell_attr[3:0];
        r = colour[2];
        g = colour[1];
        b = colour[0];
        if (colour[3]) begin
            r = 2 * r;
            g = 2 * g;
            b = 2 * b;
        end
        red_sum += r;
        green_sum += g;
        blue_sum += b;
        cells_in_tile++;
        n = eff_side(tile_w) * eff_side(tile_h);
        if (cells_in_tile < n)
            return;
        // Average brightness is S / (9 N); the level is the first of eight bands
        // whose upper edge k / 4 it does not exceed.
        s = 3 * red_sum + 2 * green_sum + 3 * blue_sum;
        lvl = 7;
        for (k = 7; k >= 1; k--) begin
            if (4 * s <= 9 * k * n)
                lvl = k - 1;
        end
        case (lvl % 4)
            0:       t.tile_char = SHADE_LIGHT;
            1:       t.tile_char = SHADE_MEDIUM;
            2:       t.tile_char = SHADE_DARK;
            default: t.tile_char = SHADE_FULL;
        endcase
        t.tile_attr = {lvl >= 4, 2 * red_sum >= n, 4 * green_sum >= 3 * n, 2 * blue_sum >= n};
        t.attr_changed = (t.tile_attr != last_attr);
        last_attr = t.tile_attr;
        clear_tile();
        tiles_due.push_back(t);
    endtask

    // Cell driver: presents queued words, predicts on every accepted one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_cell_valid <= 1'b0;
            tile_w = TCTD_SIDE_RESET;
            tile_h = TCTD_SIDE_RESET;
            last_attr = '0;
            clear_tile();
        end else begin
            // A word taken at the same edge as a register write still sees the old size.
            if (i_cell_valid && o_cell_ready) begin
                accumulate_cell(i_cell);
                cells_taken++;
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_TILE_WIDTH)
                    tile_w = i_cfg_data;
                else
                    tile_h = i_cfg_data;
            end
            if (!i_cell_valid || o_cell_ready) begin
                if (cells_todo.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
                    i_cell <= cells_todo.pop_front();
                    i_cell_valid <= 1'b1;
                end else begin
                    i_cell_valid <= 1'b0;
                end
            end
        end
    end

    // Tile receiver: random stalls, plus a long hold whenever one is requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_tile_ready <= 1'b0;
        end else if (hold_req != hold_taken) begin
            hold_taken = hold_req;
            hold_left = HOLD_CYCLES;
            i_tile_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_tile_ready <= 1'b0;
        end else begin
            i_tile_ready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
        end
    end

    // Tile monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && o_tile_valid && i_tile_ready) begin
            if (tiles_due.size() == 0) begin
                $display("%0t: unexpected tile word: expected none, got %p", $time, o_tile);
                fail_count++;
            end else begin
                tile_want = tiles_due.pop_front();
                tiles_checked++;
                if (o_tile.tile_char !== tile_want.tile_char) begin
                    $display("%0t: tile_char expected %h, got %h",
                             $time, tile_want.tile_char, o_tile.tile_char);
                    fail_count++;
                end
                if (o_tile.tile_attr !== tile_want.tile_attr) begin
                    $display("%0t: tile_attr expected %h, got %h",
                             $time, tile_want.tile_attr, o_tile.tile_attr);
                    fail_count++;
                end
                if (o_tile.attr_changed !== tile_want.attr_changed) begin
                    $display("%0t: attr_changed expected %b, got %b",
                             $time, tile_want.attr_changed, o_tile.attr_changed);
                    fail_count++;
                end
            end
        end
    end

    task automatic queue_cell(input logic [7:0] ch, input logic [7:0] attr, input bit fs);
        t_cell_in c;
        c.cell_char = ch;
        c.cell_attr = attr;
        c.frame_start = fs;
        cells_todo.push_back(c);
        cells_queued++;
    endtask

    // Waits until every queued word is taken and every tile seen, then lets the
    // pipeline settle so a word that completes no tile is fully absorbed.
    task automatic wait_idle();
        while (cells_taken != cells_queued || tiles_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_side(input t_cfg_reg which, input logic [TCTD_CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= which;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Half the tiles share one attribute so that whole tiles land on extreme levels;
    // frames mostly restart on tile boundaries, now and then in the middle of a tile.
    task automatic queue_random(input int count, input int unsigned n);
        int         k;
        logic [7:0] theme, ch, attr;
        bit         themed, fs;
        for (k = 0; k < count; k++) begin
            if (k % n == 0) begin
                theme = $urandom;
                themed = $urandom_range(0, 1);
            end
            case ($urandom_range(0, 9))
                0, 1, 2: ch = CHAR_NUL;
                3, 4:    ch = CHAR_SPACE;
                default: ch = $urandom;
            endcase
            attr = (themed && $urandom_range(0, 7) != 0) ? theme : 8'($urandom);
            fs = (k == 0) || (k % n == 0 && $urandom_range(0, 7) == 0)
                 || $urandom_range(0, 39) == 0;
            queue_cell(ch, attr, fs);
        end
    endtask

    task automatic run_phase(input logic [TCTD_CFG_W-1:0] w, input logic [TCTD_CFG_W-1:0] h,
                             input int count, input t_idle_mode mode);
        wait_idle();
        idle_mode = mode;
        set_side(CFG_TILE_WIDTH, w);
        set_side(CFG_TILE_HEIGHT, h);
        queue_random(count, eff_side(w) * eff_side(h));
    endtask

    initial begin
        int         i;
        logic [3:0] c4;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // One-cell tiles: every colour once, picked as background (NUL, space) or
        // foreground, with a frame restart partway through.
        set_side(CFG_TILE_WIDTH, 5'd1);
        set_side(CFG_TILE_HEIGHT, 5'd1);
        for (i = 0; i < 16; i++) begin
            c4 = i[3:0];
            case (i % 3)
                0:       queue_cell(CHAR_NUL, {c4, ~c4}, i == 0 || i == 9);
                1:       queue_cell(CHAR_SPACE, {c4, ~c4}, 1'b0);
                default: queue_cell(8'hFF - 8'(i), {~c4, c4}, 1'b0);
            endcase
        end

        // Three cells of a 2x2 tile, then the width drops to one: the count already
        // exceeds the new size, so the next cell closes the tile.
        wait_idle();
        set_side(CFG_TILE_WIDTH, 5'd2);
        set_side(CFG_TILE_HEIGHT, 5'd2);
        queue_cell(8'h41, 8'h1F, 1'b0);
        queue_cell(CHAR_SPACE, 8'hC0, 1'b0);
        queue_cell(CHAR_NUL, 8'h90, 1'b0);
        wait_idle();
        set_side(CFG_TILE_WIDTH, 5'd1);
        queue_cell(8'h7E, 8'h0E, 1'b0);

        // Frame restart in the middle of a 1x2 tile drops the partial tile.
        queue_cell(8'h80, 8'h0F, 1'b0);
        queue_cell(8'h2A, 8'h0A, 1'b1);
        queue_cell(CHAR_NUL, 8'hA0, 1'b0);

        // The output stalls for a long stretch while one-cell tiles keep coming.
        run_phase(5'd1, 5'd1, 50, IDLE_RX_HEAVY);
        hold_req <= hold_req + 1;
        run_phase(5'd2, 5'd1, 20, IDLE_RX_HEAVY);
        run_phase(5'd2, 5'd2, 24, IDLE_RX_HEAVY);
        run_phase(5'd0, 5'd0, 20, IDLE_TX_HEAVY);
        run_phase(5'd3, 5'd2, 24, IDLE_TX_HEAVY);
        run_phase(5'd1, 5'd5, 10, IDLE_TX_HEAVY);

        // Largest tile, all bright white: the channel sums reach their maximum.
        wait_idle();
        idle_mode = IDLE_NONE;
        set_side(CFG_TILE_WIDTH, 5'd31);
        set_side(CFG_TILE_HEIGHT, 5'd16);
        for (i = 0; i < 256; i++)
            queue_cell(8'($urandom_range(1, 31)), {4'($urandom), 4'hF}, i == 0);

        run_phase(5'd5, 5'd3, 30, IDLE_NONE);
        wait_idle();
        repeat (10) @(posedge i_clk);

        $display("Checked %0d tiles from %0d cells, sides 1 to 16 and out-of-range values,",
                 tiles_checked, cells_taken);
        $display("with mid-tile size changes, frame restarts and a %0d-cycle output stall.",
                 HOLD_CYCLES);
        if (fail_count == 0)
            $display("tb_text_cell_tile_downsampler: clean");
        else
            $display("tb_text_cell_tile_downsampler: errors");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timed out waiting for the block.");
        $display("tb_text_cell_tile_downsampler: errors");
        $finish;
    end

endmodule
